// ----- rtl/sntt_pkg.sv -----
`timescale 1ns / 1ps

package sntt_pkg;

  localparam logic [31:0] MAX_B36 = 32'd2176782335;
  localparam logic [31:0] MIN_B36 = 32'd16796160;

  localparam logic [2:0] DEC_LAST_IDX = 3'd7;
  localparam logic [2:0] B36_LAST_IDX = 3'd5;
  localparam logic [2:0] DEC_TOP_BIT  = 3'd3;
  localparam logic [2:0] B36_TOP_BIT  = 3'd5;

  localparam logic [6:0] CHAR_ZERO  = 7'd48;
  localparam logic [6:0] CHAR_ALPHA = 7'd55;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  function automatic logic [31:0] digit_weight(input logic b36, input logic [2:0] idx);
    logic [31:0] w;
    w = 32'd1;
    if (b36) begin
      case (idx)
        3'd0: w = 32'd60466176;
        3'd1: w = 32'd1679616;
        3'd2: w = 32'd46656;
        3'd3: w = 32'd1296;
        3'd4: w = 32'd36;
        default: w = 32'd1;
      endcase
    end else begin
      case (idx)
        3'd0: w = 32'd10000000;
        3'd1: w = 32'd1000000;
        3'd2: w = 32'd100000;
        3'd3: w = 32'd10000;
        3'd4: w = 32'd1000;
        3'd5: w = 32'd100;
        3'd6: w = 32'd10;
        default: w = 32'd1;
      endcase
    end
    return w;
  endfunction

  function automatic logic [6:0] digit_char(input logic [5:0] d);
    logic [6:0] c;
    if (d < 6'd10) begin
      c = CHAR_ZERO + {1'b0, d};
    end else begin
      c = CHAR_ALPHA + {1'b0, d};
    end
    return c;
  endfunction

endpackage

// ----- rtl/serial_number_to_text_unit.sv -----
`timescale 1ns / 1ps

// Formats a 32-bit serial number as ASCII text, one character per output request,
// most significant first, with out_last on the final character. Zero and values
// above 36^6-1 give the single character '0'; values below 16796160 are written in
// decimal without leading zeros; all others as six base-36 digits (0-9, A-Z). Digits
// come from one shared compare-and-subtract unit doing restoring division by the
// digit weight, one quotient bit per cycle, each digit followed by an emit step that
// waits while the output register is full and stalled. in_stall is high whenever the
// block is not idle, so the next request waits until the last character is emitted.
module serial_number_to_text_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_serial,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  out_character,
  output logic        out_last
);

  sntt_pkg::state_t state_r, state_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [2:0]  widx_r, widx_nxt;
  logic [2:0]  bit_r, bit_nxt;
  logic [5:0]  q_r, q_nxt;
  logic        b36_r, b36_nxt;
  logic        started_r, started_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [6:0]  out_char_r, out_char_nxt;
  logic        out_last_r, out_last_nxt;

  logic [31:0] trial;
  logic        fits;
  logic        accept;
  logic        slot_free;
  logic        at_last;
  logic        show;

  assign trial     = sntt_pkg::digit_weight(b36_r, widx_r) << bit_r;
  assign fits      = rem_r >= trial;
  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign at_last   = b36_r ? (widx_r == sntt_pkg::B36_LAST_IDX)
                           : (widx_r == sntt_pkg::DEC_LAST_IDX);
  assign show      = started_r || (q_r != 6'd0) || at_last;

  assign in_stall      = (state_r != sntt_pkg::ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

  always_comb begin
    state_nxt     = state_r;
    rem_nxt       = rem_r;
    widx_nxt      = widx_r;
    bit_nxt       = bit_r;
    q_nxt         = q_r;
    b36_nxt       = b36_r;
    started_nxt   = started_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      sntt_pkg::ST_IDLE: begin
        if (accept) begin
          rem_nxt     = in_serial;
          q_nxt       = 6'd0;
          started_nxt = 1'b0;
          if (in_serial == 32'd0 || in_serial > sntt_pkg::MAX_B36) begin
            b36_nxt     = 1'b0;
            widx_nxt    = sntt_pkg::DEC_LAST_IDX;
            started_nxt = 1'b1;
            state_nxt   = sntt_pkg::ST_EMIT;
          end else if (in_serial < sntt_pkg::MIN_B36) begin
            b36_nxt   = 1'b0;
            widx_nxt  = 3'd0;
            bit_nxt   = sntt_pkg::DEC_TOP_BIT;
            state_nxt = sntt_pkg::ST_CALC;
          end else begin
            b36_nxt     = 1'b1;
            widx_nxt    = 3'd0;
            bit_nxt     = sntt_pkg::B36_TOP_BIT;
            started_nxt = 1'b1;
            state_nxt   = sntt_pkg::ST_CALC;
          end
        end
      end
      sntt_pkg::ST_CALC: begin
        if (fits) begin
          rem_nxt = rem_r - trial;
          q_nxt   = q_r | (6'd1 << bit_r);
        end
        if (bit_r == 3'd0) begin
          state_nxt = sntt_pkg::ST_EMIT;
        end else begin
          bit_nxt = bit_r - 3'd1;
        end
      end
      sntt_pkg::ST_EMIT: begin
        if (!show || slot_free) begin
          if (show) begin
            out_valid_nxt = 1'b1;
            out_char_nxt  = sntt_pkg::digit_char(q_r);
            out_last_nxt  = at_last;
            started_nxt   = 1'b1;
          end
          if (at_last) begin
            state_nxt = sntt_pkg::ST_IDLE;
          end else begin
            widx_nxt  = widx_r + 3'd1;
            bit_nxt   = b36_r ? sntt_pkg::B36_TOP_BIT : sntt_pkg::DEC_TOP_BIT;
            q_nxt     = 6'd0;
            state_nxt = sntt_pkg::ST_CALC;
          end
        end
      end
      default: state_nxt = sntt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sntt_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      started_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      started_r   <= started_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    widx_r     <= widx_nxt;
    bit_r      <= bit_nxt;
    q_r        <= q_nxt;
    b36_r      <= b36_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != sntt_pkg::ST_IDLE))
    else $error("block idle after accepting a request");

  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sntt_pkg::ST_EMIT) |-> (b36_r ? (q_r <= 6'd35) : (q_r <= 6'd9)))
    else $error("digit out of range");

  a_final_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sntt_pkg::ST_EMIT && at_last && !started_r) |-> (q_r != 6'd0))
    else $error("no character produced for request");

endmodule

// ----- test/tb_serial_number_to_text_unit.sv -----
`timescale 1ns / 1ps

module tb_serial_number_to_text_unit;

  localparam logic [6:0] CHAR_UPPER_A = 7'd65;
  localparam logic [31:0] TOP_B36_WEIGHT = 32'd60466176;
  localparam int DIRECTED_COUNT = 24;
  localparam int RANDOM_COUNT = 406;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int QUIET_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [6:0] character;
    logic       last;
  } text_char_t;

  class text_scoreboard;
    text_char_t pending[$];
    int errors;
    int chars_checked;
    int n_decimal;
    int n_base36;
    int n_single_zero;

    function new();
      errors = 0;
      chars_checked = 0;
      n_decimal = 0;
      n_base36 = 0;
      n_single_zero = 0;
    endfunction

    static function logic [6:0] ascii_of(logic [31:0] d);
      if (d < 10) begin
        return sntt_pkg::CHAR_ZERO + d[6:0];
      end
      return CHAR_UPPER_A + d[6:0] - 7'd10;
    endfunction

    function void note_serial(logic [31:0] serial);
      logic [31:0] rest;
      logic [31:0] weight;
      logic [31:0] q;
      logic [6:0] digits[$];
      text_char_t c;
      rest = serial;
      if (serial == 0 || serial > sntt_pkg::MAX_B36) begin
        digits.push_back(sntt_pkg::CHAR_ZERO);
        n_single_zero++;
      end else if (serial < sntt_pkg::MIN_B36) begin
        while (rest != 0) begin
          digits.push_front(ascii_of(rest % 10));
          rest = rest / 10;
        end
        n_decimal++;
      end else begin
        weight = TOP_B36_WEIGHT;
        for (int k = 0; k < 6; k++) begin
          q = rest / weight;
          if (q > 35) begin
            q = 35;
          end
          rest = rest - q * weight;
          digits.push_back(ascii_of(q));
          weight = weight / 36;
        end
        n_base36++;
      end
      for (int k = 0; k < digits.size(); k++) begin
        c.character = digits[k];
        c.last = (k == digits.size() - 1);
        pending.push_back(c);
      end
    endfunction

    task report(string msg);
      if (errors < 40) begin
        $display("mismatch at %0t: %s", $time, msg);
      end
      errors++;
    endtask

    task check_char(logic [6:0] character, logic last);
      text_char_t want;
      if (pending.size() == 0) begin
        report($sformatf("character %0d last %0b with nothing pending", character, last));
      end else begin
        want = pending.pop_front();
        chars_checked++;
        if (character !== want.character) begin
          report($sformatf("character %0d, wanted %0d", character, want.character));
        end
        if (last !== want.last) begin
          report($sformatf("last %0b on character %0d, wanted %0b", last, character, want.last));
        end
      end
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_serial;
  logic        out_valid;
  logic        out_stall;
  logic [6:0]  out_character;
  logic        out_last;

  text_scoreboard sb;
  int burst_left;
  int cycle_count;
  int hold_left;
  logic hold_req;
  logic hold_done;
  int quiet_cycles;

  serial_number_to_text_unit i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_serial     (in_serial),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_character (out_character),
    .out_last      (out_last)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // sender: bursts of requests separated by random gaps
  task automatic send_serial(input logic [31:0] serial);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
    end
    in_valid <= 1'b1;
    in_serial <= serial;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_serial(serial);
    burst_left--;
  endtask

  function automatic logic [31:0] pick_serial();
    int sel;
    int n;
    logic [31:0] lo;
    logic [31:0] hi;
    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      n = $urandom_range(1, 8);
      lo = 1;
      repeat (n - 1) lo = lo * 10;
      hi = lo * 10 - 1;
      if (hi >= sntt_pkg::MIN_B36) begin
        hi = sntt_pkg::MIN_B36 - 1;
      end
      return $urandom_range(hi, lo);
    end else if (sel < 75) begin
      return $urandom_range(sntt_pkg::MAX_B36, sntt_pkg::MIN_B36);
    end else if (sel < 93) begin
      return $urandom;
    end
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return sntt_pkg::MIN_B36 - 1;
      2: return sntt_pkg::MIN_B36;
      3: return sntt_pkg::MAX_B36;
      4: return sntt_pkg::MAX_B36 + 1;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  // receiver: check each accepted character, stall on a shifting pattern and one long hold-off
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_char(out_character, out_last);
    end
    cycle_count <= cycle_count + 1;
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_OFF_CYCLES;
      hold_done <= 1'b1;
    end else begin
      case ((cycle_count / 256) % 4)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 1) == 0);
        2: out_stall <= ($urandom_range(0, 4) == 0);
        default: out_stall <= (cycle_count % 5 < 2);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] directed [DIRECTED_COUNT];
    sb = new();
    burst_left = 0;
    cycle_count = 0;
    hold_left = 0;
    quiet_cycles = 0;
    hold_req <= 1'b0;
    hold_done <= 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_serial <= 32'd0;
    out_stall <= 1'b0;
    directed = '{
      32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd10000000, 32'd12345678,
      sntt_pkg::MIN_B36 - 1, sntt_pkg::MIN_B36, 32'd60466175, TOP_B36_WEIGHT,
      32'd1679616, 32'd46656,
      32'd99999999, 32'h7FFF_FFFF, 32'h8000_0000, 32'h5555_5555, sntt_pkg::MAX_B36 - 1,
      sntt_pkg::MAX_B36, sntt_pkg::MAX_B36 + 1, 32'hAAAA_AAAA, 32'hFFFF_FFFE,
      32'hFFFF_FFFF
    };
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed[k]) begin
      send_serial(directed[k]);
    end
    hold_req <= 1'b1;
    repeat (RANDOM_COUNT) send_serial(pick_serial());
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d decimal, %0d base-36 and %0d single-zero serial numbers",
             sb.n_decimal, sb.n_base36, sb.n_single_zero);
    $display("checked %0d characters with one long output hold-off, %0d mismatches",
             sb.chars_checked, sb.errors);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
